[rtl/core/iigbm_pkg.sv]
// shared types, register indexes and widths for the grid block mean unit
package iigbm_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_X_OFFSET = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_Y_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_WIDTH    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_HEIGHT   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_ACROSS   = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCKS_DOWN     = 3'd7;

    // input word actions
    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    // datapath widths
    localparam int VAL_W     = 48;
    localparam int SUM_W     = VAL_W + 1;
    localparam int DIV_DD_W  = SUM_W;
    localparam int DIV_DS_W  = 21;
    localparam int DIV_CNT_W = 6;

    // divider step counts: width of the dividend that is actually used
    localparam logic [DIV_CNT_W-1:0] DIVX_STEPS = 6'd11;
    localparam logic [DIV_CNT_W-1:0] DIVY_STEPS = 6'd10;
    localparam logic [DIV_CNT_W-1:0] DIVM_STEPS = 6'(DIV_DD_W);

    typedef struct packed {
        logic             action;
        logic [8:0]       load_row;
        logic [9:0]       load_col;
        logic [VAL_W-1:0] load_value;
        logic [3:0]       cell_x;
        logic [3:0]       cell_y;
    } in_word_t;

    typedef struct packed {
        logic [VAL_W-1:0] cell_mean;
        logic             geometry_error;
    } out_word_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_CNT_W-1:0] steps;
    } div_ctl_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIVX_GO,
        ST_DIVX_WAIT,
        ST_DIVY_GO,
        ST_DIVY_WAIT,
        ST_GEOM,
        ST_CORNER,
        ST_RD_A,
        ST_RD_B,
        ST_RD_C,
        ST_RD_D,
        ST_RD_E,
        ST_DIFF,
        ST_DIVM_GO,
        ST_DIVM_WAIT,
        ST_FIN
    } state_t;

endpackage

[rtl/core/iigbm_ram.sv]
// generic single write port, single read port ram with registered read
module iigbm_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/iigbm_div.sv]
// bit-serial restoring divider, one quotient bit per cycle
module iigbm_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  iigbm_pkg::div_ctl_t                 ctl,
    input  logic [iigbm_pkg::DIV_DD_W-1:0]      dividend,
    input  logic [iigbm_pkg::DIV_DS_W-1:0]      divisor,
    output logic                                done,
    output logic [iigbm_pkg::DIV_DD_W-1:0]      quotient
);

    localparam int DD_W  = iigbm_pkg::DIV_DD_W;
    localparam int DS_W  = iigbm_pkg::DIV_DS_W;
    localparam int CNT_W = iigbm_pkg::DIV_CNT_W;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DD_W-1:0]  quo_reg;
    logic [DS_W-1:0]  rem_reg;
    logic [DS_W-1:0]  dvs_reg;

    logic [DS_W:0]    trial;
    logic [DS_W:0]    trial_sub;
    logic             trial_ge;
    logic [DS_W-1:0]  rem_step;

    // one restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial     = {rem_reg, quo_reg[DD_W-1]};
        trial_ge  = (trial >= {1'b0, dvs_reg});
        trial_sub = trial - {1'b0, dvs_reg};
        rem_step  = trial_ge ? trial_sub[DS_W-1:0] : trial[DS_W-1:0];
    end

    // step counter and completion pulse
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (ctl.start) begin
            busy_next = 1'b1;
            cnt_next  = ctl.steps;
        end else if (busy_reg) begin
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // quotient shifts in from the bottom as dividend bits leave the top
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DD_W-2:0], trial_ge};
            rem_reg <= rem_step;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

[rtl/core/integral_image_grid_block_mean.sv]
// Grid cell mean over one stored plane of an integral image. Load words write one 48-bit
// entry each into an on-chip ram of MAX_ROWS x MAX_COLS entries (row * MAX_COLS + col) and
// are taken one per cycle while idle; entries must be written before any query reads
// them, and the ram is never cleared. A query word names a grid cell of the configured
// window; the block clamps the window to the convolved image, derives the cell spacing
// with two divisions, reads the four corners, and divides the box sum by the cell area
// with floor, giving one result word (geometry_error set and mean zero when a spacing is
// zero or negative). The result word becomes valid and input ready returns in the same
// cycle, later only while an earlier result word is still stalled at the output: one
// bit-serial divider is shared for the 11-step and 10-step spacing divisions and the
// 49-step mean division, and the four corner reads go through the single read port of
// the ram. The user must write configuration only while no query is in flight (unchecked).
module integral_image_grid_block_mean #(
    parameter int MAX_COLS    = 1024,
    parameter int MAX_ROWS    = 512,
    parameter int KERNEL_EDGE = 21,
    parameter int MAX_GRID    = 10
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  iigbm_pkg::in_word_t                 s_word,
    output logic                                m_valid,
    input  logic                                m_ready,
    output iigbm_pkg::out_word_t                m_word,
    input  logic                                cfg_wr_en,
    input  logic [iigbm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [iigbm_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int VAL_W = iigbm_pkg::VAL_W;
    localparam int SUM_W = iigbm_pkg::SUM_W;
    localparam int DD_W  = iigbm_pkg::DIV_DD_W;
    localparam int DS_W  = iigbm_pkg::DIV_DS_W;

    // configuration registers
    logic [10:0] img_w_reg;
    logic [9:0]  img_h_reg;
    logic [10:0] x_off_reg;
    logic [9:0]  y_off_reg;
    logic [10:0] win_w_reg;
    logic [9:0]  win_h_reg;
    logic [3:0]  blk_x_reg;
    logic [3:0]  blk_y_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            img_w_reg <= 11'd640;
            img_h_reg <= 10'd480;
            x_off_reg <= '0;
            y_off_reg <= '0;
            win_w_reg <= 11'd256;
            win_h_reg <= 10'd256;
            blk_x_reg <= 4'd4;
            blk_y_reg <= 4'd4;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                iigbm_pkg::CFG_IMAGE_WIDTH:     img_w_reg <= cfg_wdata[10:0];
                iigbm_pkg::CFG_IMAGE_HEIGHT:    img_h_reg <= cfg_wdata[9:0];
                iigbm_pkg::CFG_WINDOW_X_OFFSET: x_off_reg <= cfg_wdata[10:0];
                iigbm_pkg::CFG_WINDOW_Y_OFFSET: y_off_reg <= cfg_wdata[9:0];
                iigbm_pkg::CFG_WINDOW_WIDTH:    win_w_reg <= cfg_wdata[10:0];
                iigbm_pkg::CFG_WINDOW_HEIGHT:   win_h_reg <= cfg_wdata[9:0];
                iigbm_pkg::CFG_BLOCKS_ACROSS:   blk_x_reg <= cfg_wdata[3:0];
                iigbm_pkg::CFG_BLOCKS_DOWN:     blk_y_reg <= cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    iigbm_pkg::state_t state_reg, state_next;

    // query datapath registers
    logic [3:0]         cell_x_reg, cell_y_reg;
    logic signed [11:0] cols_reg;
    logic signed [10:0] rows_reg;
    logic signed [11:0] ww_reg;
    logic signed [10:0] wh_reg;
    logic [3:0]         bx_reg, by_reg;
    logic               bad_x_reg, bad_y_reg;
    logic [10:0]        sxq_reg, sx_reg;
    logic [9:0]         syq_reg, sy_reg;
    logic [10:0]        ox_reg;
    logic [9:0]         oy_reg;
    logic [10:0]        x0_reg, x1_reg;
    logic [9:0]         y0_reg, y1_reg;
    logic [DS_W-1:0]    area_reg;
    logic               rd_ok_reg;
    logic [SUM_W-1:0]   pos_reg, neg_reg, diff_reg;
    logic [VAL_W-1:0]   mean_res_reg;
    logic               err_res_reg;
    logic [VAL_W-1:0]   mean_out_reg;
    logic               err_out_reg;
    logic               m_valid_reg, m_valid_next;

    // shared divider
    iigbm_pkg::div_ctl_t div_ctl;
    logic [DD_W-1:0]     div_dividend;
    logic [DS_W-1:0]     div_divisor;
    logic                div_done;
    logic [DD_W-1:0]     div_q;

    iigbm_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // plane memory
    logic             ld_ok;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [AW-1:0]    ram_raddr;
    logic [VAL_W-1:0] ram_rdata;
    logic [10:0]      rd_x;
    logic [9:0]       rd_y;
    logic             rd_ok;
    logic [VAL_W-1:0] rd_val;

    assign ld_ok = (13'(s_word.load_row) < 13'(MAX_ROWS)) &&
                   (13'(s_word.load_col) < 13'(MAX_COLS));
    assign ram_we = s_valid && s_ready && (s_word.action == iigbm_pkg::ACT_LOAD) && ld_ok;
    assign ram_waddr = AW'(s_word.load_row) * AW'(MAX_COLS) + AW'(s_word.load_col);
    assign ram_raddr = AW'(rd_y) * AW'(MAX_COLS) + AW'(rd_x);
    assign rd_ok = (13'(rd_x) < 13'(MAX_COLS)) && (13'(rd_y) < 13'(MAX_ROWS));
    assign rd_val = rd_ok_reg ? ram_rdata : '0;

    iigbm_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_plane (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_word.load_value),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // convolved size, clamped window and saturated block counts
    logic signed [11:0] cols_c, ww_c, win_w_s;
    logic signed [10:0] rows_c, wh_c, win_h_s;
    logic [3:0]         bx_c, by_c;

    always_comb begin
        win_w_s = $signed({1'b0, win_w_reg});
        win_h_s = $signed({1'b0, win_h_reg});
        cols_c  = $signed({1'b0, img_w_reg}) - $signed(12'(KERNEL_EDGE + 1));
        rows_c  = $signed({1'b0, img_h_reg}) - $signed(11'(KERNEL_EDGE + 1));
        ww_c    = (win_w_s > cols_c) ? cols_c : win_w_s;
        wh_c    = (win_h_s > rows_c) ? rows_c : win_h_s;
        bx_c    = ({2'b0, blk_x_reg} > 6'(MAX_GRID)) ? 4'(MAX_GRID) : blk_x_reg;
        by_c    = ({2'b0, blk_y_reg} > 6'(MAX_GRID)) ? 4'(MAX_GRID) : blk_y_reg;
    end

    // window origin, centred plus offset, clamped inside the convolved image
    logic signed [12:0] xo_ext, cols_e, ww_e, ox_raw, ox_lim;
    logic signed [11:0] yo_ext, rows_e, wh_e, oy_raw, oy_lim;
    logic [10:0]        ox_c;
    logic [9:0]         oy_c;
    logic               geom_err;

    always_comb begin
        xo_ext = {{2{x_off_reg[10]}}, x_off_reg};
        cols_e = {cols_reg[11], cols_reg};
        ww_e   = {ww_reg[11], ww_reg};
        ox_raw = xo_ext + (cols_e >>> 1) - (ww_e >>> 1);
        ox_lim = cols_e - ww_e;
        if (ox_raw < 13'sd0) begin
            ox_c = '0;
        end else if (ox_raw > ox_lim) begin
            ox_c = ox_lim[10:0];
        end else begin
            ox_c = ox_raw[10:0];
        end
        yo_ext = {{2{y_off_reg[9]}}, y_off_reg};
        rows_e = {rows_reg[10], rows_reg};
        wh_e   = {wh_reg[10], wh_reg};
        oy_raw = yo_ext + (rows_e >>> 1) - (wh_e >>> 1);
        oy_lim = rows_e - wh_e;
        if (oy_raw < 12'sd0) begin
            oy_c = '0;
        end else if (oy_raw > oy_lim) begin
            oy_c = oy_lim[9:0];
        end else begin
            oy_c = oy_raw[9:0];
        end
        geom_err = bad_x_reg || bad_y_reg || (sxq_reg <= 11'd1) || (syq_reg <= 10'd1);
    end

    // cell corners
    logic [3:0]  cx_c, cy_c;
    logic [14:0] px_c;
    logic [13:0] py_c;
    logic [10:0] x0_c;
    logic [9:0]  y0_c;

    always_comb begin
        cx_c = (cell_x_reg >= bx_reg) ? bx_reg - 4'd1 : cell_x_reg;
        cy_c = (cell_y_reg >= by_reg) ? by_reg - 4'd1 : cell_y_reg;
        px_c = 15'(cx_c) * 15'(sx_reg);
        py_c = 14'(cy_c) * 14'(sy_reg);
        x0_c = ox_reg + px_c[10:0];
        y0_c = oy_reg + py_c[9:0];
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            iigbm_pkg::ST_IDLE: begin
                if (s_valid && (s_word.action == iigbm_pkg::ACT_QUERY)) begin
                    state_next = iigbm_pkg::ST_PREP;
                end
            end
            iigbm_pkg::ST_PREP:      state_next = iigbm_pkg::ST_DIVX_GO;
            iigbm_pkg::ST_DIVX_GO:   state_next = iigbm_pkg::ST_DIVX_WAIT;
            iigbm_pkg::ST_DIVX_WAIT: begin
                if (div_done) begin
                    state_next = iigbm_pkg::ST_DIVY_GO;
                end
            end
            iigbm_pkg::ST_DIVY_GO:   state_next = iigbm_pkg::ST_DIVY_WAIT;
            iigbm_pkg::ST_DIVY_WAIT: begin
                if (div_done) begin
                    state_next = iigbm_pkg::ST_GEOM;
                end
            end
            iigbm_pkg::ST_GEOM: begin
                state_next = geom_err ? iigbm_pkg::ST_FIN : iigbm_pkg::ST_CORNER;
            end
            iigbm_pkg::ST_CORNER:    state_next = iigbm_pkg::ST_RD_A;
            iigbm_pkg::ST_RD_A:      state_next = iigbm_pkg::ST_RD_B;
            iigbm_pkg::ST_RD_B:      state_next = iigbm_pkg::ST_RD_C;
            iigbm_pkg::ST_RD_C:      state_next = iigbm_pkg::ST_RD_D;
            iigbm_pkg::ST_RD_D:      state_next = iigbm_pkg::ST_RD_E;
            iigbm_pkg::ST_RD_E:      state_next = iigbm_pkg::ST_DIFF;
            iigbm_pkg::ST_DIFF:      state_next = iigbm_pkg::ST_DIVM_GO;
            iigbm_pkg::ST_DIVM_GO:   state_next = iigbm_pkg::ST_DIVM_WAIT;
            iigbm_pkg::ST_DIVM_WAIT: begin
                if (div_done) begin
                    state_next = iigbm_pkg::ST_FIN;
                end
            end
            iigbm_pkg::ST_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = iigbm_pkg::ST_IDLE;
                end
            end
            default: state_next = iigbm_pkg::ST_IDLE;
        endcase
    end

    // state outputs: input ready, divider operands, corner address
    always_comb begin
        s_ready       = (state_reg == iigbm_pkg::ST_IDLE);
        div_ctl.start = 1'b0;
        div_ctl.steps = iigbm_pkg::DIVM_STEPS;
        div_dividend  = diff_reg;
        div_divisor   = area_reg;
        rd_x          = x1_reg;
        rd_y          = y1_reg;
        case (state_reg)
            iigbm_pkg::ST_DIVX_GO: begin
                div_ctl.start = 1'b1;
                div_ctl.steps = iigbm_pkg::DIVX_STEPS;
                div_dividend  = {ww_reg[10:0], {(DD_W - 11){1'b0}}};
                div_divisor   = DS_W'(bx_reg);
            end
            iigbm_pkg::ST_DIVY_GO: begin
                div_ctl.start = 1'b1;
                div_ctl.steps = iigbm_pkg::DIVY_STEPS;
                div_dividend  = {wh_reg[9:0], {(DD_W - 10){1'b0}}};
                div_divisor   = DS_W'(by_reg);
            end
            iigbm_pkg::ST_DIVM_GO: begin
                div_ctl.start = 1'b1;
            end
            iigbm_pkg::ST_RD_B: begin
                rd_x = x0_reg;
                rd_y = y0_reg;
            end
            iigbm_pkg::ST_RD_C: begin
                rd_x = x0_reg;
                rd_y = y1_reg;
            end
            iigbm_pkg::ST_RD_D: begin
                rd_x = x1_reg;
                rd_y = y0_reg;
            end
            default: begin
            end
        endcase
    end

    // result word valid flag
    always_comb begin
        m_valid_next = m_valid_reg;
        if ((state_reg == iigbm_pkg::ST_FIN) && (!m_valid_reg || m_ready)) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= iigbm_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // query datapath
    always_ff @(posedge aclk) begin
        rd_ok_reg <= rd_ok;
        case (state_reg)
            iigbm_pkg::ST_IDLE: begin
                cell_x_reg <= s_word.cell_x;
                cell_y_reg <= s_word.cell_y;
            end
            iigbm_pkg::ST_PREP: begin
                cols_reg  <= cols_c;
                rows_reg  <= rows_c;
                ww_reg    <= ww_c;
                wh_reg    <= wh_c;
                bx_reg    <= bx_c;
                by_reg    <= by_c;
                bad_x_reg <= (ww_c <= 12'sd0) || (bx_c == 4'd0);
                bad_y_reg <= (wh_c <= 11'sd0) || (by_c == 4'd0);
            end
            iigbm_pkg::ST_DIVX_WAIT: begin
                sxq_reg <= div_q[10:0];
            end
            iigbm_pkg::ST_DIVY_WAIT: begin
                syq_reg <= div_q[9:0];
            end
            iigbm_pkg::ST_GEOM: begin
                sx_reg       <= sxq_reg - 11'd1;
                sy_reg       <= syq_reg - 10'd1;
                ox_reg       <= ox_c;
                oy_reg       <= oy_c;
                mean_res_reg <= '0;
                err_res_reg  <= 1'b1;
            end
            iigbm_pkg::ST_CORNER: begin
                x0_reg   <= x0_c;
                x1_reg   <= x0_c + sx_reg;
                y0_reg   <= y0_c;
                y1_reg   <= y0_c + sy_reg;
                area_reg <= DS_W'(sx_reg) * DS_W'(sy_reg);
            end
            iigbm_pkg::ST_RD_B: pos_reg <= SUM_W'(rd_val);
            iigbm_pkg::ST_RD_C: pos_reg <= pos_reg + SUM_W'(rd_val);
            iigbm_pkg::ST_RD_D: neg_reg <= SUM_W'(rd_val);
            iigbm_pkg::ST_RD_E: neg_reg <= neg_reg + SUM_W'(rd_val);
            iigbm_pkg::ST_DIFF: begin
                diff_reg <= (pos_reg > neg_reg) ? pos_reg - neg_reg : '0;
            end
            iigbm_pkg::ST_DIVM_WAIT: begin
                mean_res_reg <= div_q[DD_W-1] ? {VAL_W{1'b1}} : div_q[VAL_W-1:0];
                err_res_reg  <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if ((state_reg == iigbm_pkg::ST_FIN) && (!m_valid_reg || m_ready)) begin
            mean_out_reg <= mean_res_reg;
            err_out_reg  <= err_res_reg;
        end
    end

    assign m_valid               = m_valid_reg;
    assign m_word.cell_mean      = mean_out_reg;
    assign m_word.geometry_error = err_out_reg;

endmodule

[rtl/core/iigbm_chk.sv]
// port-level checker for the grid block mean unit, bound to the top level
module iigbm_chk (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_valid,
    input logic                              s_ready,
    input iigbm_pkg::in_word_t               s_word,
    input logic                              m_valid,
    input logic                              m_ready,
    input iigbm_pkg::out_word_t              m_word
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_word))
        else $error("result word changed while stalled");

    // an error result carries a zero mean
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_word.geometry_error |-> m_word.cell_mean == '0)
        else $error("geometry error with nonzero mean");

    // a load word never produces a result
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_word.action == iigbm_pkg::ACT_LOAD) && !m_valid
        |=> !m_valid)
        else $error("result appeared after a load word");

    // a query keeps the input side closed on the next cycle
    a_query_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_word.action == iigbm_pkg::ACT_QUERY) |=> !s_ready)
        else $error("input ready right after a query word");

endmodule

bind integral_image_grid_block_mean iigbm_chk u_iigbm_chk (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .s_valid   (s_valid),
    .s_ready   (s_ready),
    .s_word    (s_word),
    .m_valid   (m_valid),
    .m_ready   (m_ready),
    .m_word    (m_word)
);
